// File: design/multi_waveform_phase_oscillator_unit_assert.svh
// Assertion macros shared by the oscillator modules.
// Both sample on the rising edge of clock and are switched off while reset is high.
`ifndef MULTI_WAVEFORM_PHASE_OSCILLATOR_UNIT_ASSERT_SVH
`define MULTI_WAVEFORM_PHASE_OSCILLATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define MWPO_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MWPO_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/mwpo_pkg.sv
package mwpo_pkg;

   localparam int PHASE_BITS  = 32;
   localparam int SAMPLE_BITS = 16;
   localparam int FREQ_BITS   = 28;
   localparam int SR_BITS     = 18;
   localparam int WAVE_BITS   = 2;
   localparam int FRAC_SHIFT  = PHASE_BITS - 8;
   localparam int DVD_BITS    = FREQ_BITS + FRAC_SHIFT;
   localparam int CNT_BITS    = $clog2(DVD_BITS);
   localparam int SINE_DEPTH  = 1024;
   localparam int ROM_ABITS   = $clog2(SINE_DEPTH) + 1;
   localparam int IDX_BITS    = $clog2(SINE_DEPTH);
   localparam int MAG_BITS    = SAMPLE_BITS - 1;
   localparam int DATA_BITS   = 32;
   localparam int ADDR_BITS   = 3;

   localparam logic [SR_BITS-1:0]   SAMPLE_RATE_RESET = SR_BITS'(48000);
   localparam logic [WAVE_BITS-1:0] WAVE_SINE     = 2'd0;
   localparam logic [WAVE_BITS-1:0] WAVE_SQUARE   = 2'd1;
   localparam logic [WAVE_BITS-1:0] WAVE_SAW      = 2'd2;
   localparam logic [WAVE_BITS-1:0] WAVE_TRIANGLE = 2'd3;

   localparam logic REG_SAMPLE_RATE = 1'b0;
   localparam logic REG_WAVEFORM    = 1'b1;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
   localparam logic [63:0] MAX_SAMPLE  = (64'd1 << MAG_BITS) - 64'd1;
   localparam logic [63:0] SERIES_DIV [0:5] = '{64'd156, 64'd110, 64'd72,
                                                64'd42, 64'd20, 64'd6};

   typedef logic [MAG_BITS-1:0] sine_rom_type [0:SINE_DEPTH];

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // quarter-wave sine in Q30 by nested series, scaled to full sample range
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  acc;
      logic [63:0]  term;
      logic [63:0]  s;
      logic [63:0]  v;
      for (int k = 0; k <= SINE_DEPTH; k++) begin
         x   = (64'(k) * HALF_PI_Q30) / SINE_DEPTH;
         x2  = (x * x) >> 30;
         acc = ONE_Q30;
         for (int j = 0; j < 6; j++) begin
            term = ((x2 * acc) >> 30) / SERIES_DIV[j];
            acc  = (term >= ONE_Q30) ? 64'd0 : ONE_Q30 - term;
         end
         s = (x * acc) >> 30;
         v = (s * MAX_SAMPLE + (64'd1 << 29)) >> 30;
         if (v > MAX_SAMPLE) begin
            v = MAX_SAMPLE;
         end
         rom[k] = v[MAG_BITS-1:0];
      end
      rom[SINE_DEPTH] = MAX_SAMPLE[MAG_BITS-1:0];
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

// File: design/mwpo_div.sv
module mwpo_div
   import mwpo_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DVD_BITS-1:0]   dividend,
   input  logic [SR_BITS-1:0]    divisor,
   output div_status_type        status,
   output logic [PHASE_BITS-1:0] quotient
);

   localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(DVD_BITS - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [DVD_BITS-1:0]   dvd_ff, dvd_in;
   logic [SR_BITS-1:0]    rem_ff, rem_in;
   logic [PHASE_BITS-1:0] quot_ff, quot_in;
   logic [SR_BITS:0]      wide;
   logic [SR_BITS:0]      diff;
   logic                  ge;
   logic                  last;

   // restoring divide, one quotient bit per cycle; upper quotient bits fall off the top
   assign wide = {rem_ff, dvd_ff[DVD_BITS-1]};
   assign diff = wide - {1'b0, divisor};
   assign ge   = (wide >= {1'b0, divisor});
   assign last = busy_ff && (cnt_ff == LAST);

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      done_in = last;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         cnt_in  = cnt_ff + CNT_BITS'(1);
         dvd_in  = {dvd_ff[DVD_BITS-2:0], 1'b0};
         rem_in  = ge ? diff[SR_BITS-1:0] : wide[SR_BITS-1:0];
         quot_in = {quot_ff[PHASE_BITS-2:0], ge};
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quot_ff;

`include "multi_waveform_phase_oscillator_unit_assert.svh"

   `MWPO_ASSERT_IMPL(a_start_idle, start, !busy_ff, "divider restarted while busy")
   `MWPO_ASSERT_NEXT(a_last_done, last, done_ff && !busy_ff, "final step gave no done")
   `MWPO_ASSERT_IMPL(a_done_idle, done_ff, !busy_ff, "done raised while still busy")

endmodule

// File: design/multi_waveform_phase_oscillator_unit.sv
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  req_frequency  (28-bit signed, 1/256 Hz)
// rsp       out        rsp_valid / rsp_stall  rsp_sample     (16-bit signed Q1.15)
// csr       in         APB-style, pready high sample_rate @0x0, waveform @0x4
//
// From acceptance to result a request passes through the bit-serial restoring divider
// (28 magnitude bits plus 24 fraction bits), its done flag, then phase update, sine ROM
// read and output load. One request is in flight at a time; the next is accepted while
// the result still waits in the output register. Reset clears the phase and restores
// sample_rate 48000 and sine; the ROM is constant, no clearing pass. A stalled result
// holds the block in its final step until it is taken.
module multi_waveform_phase_oscillator_unit
   import mwpo_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [FREQ_BITS-1:0]  req_frequency,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [ADDR_BITS-1:0]         csr_paddr,
   input  logic [DATA_BITS-1:0]         csr_pwdata,
   output logic [DATA_BITS-1:0]         csr_prdata,
   output logic                         csr_pready
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_ACC  = 3'd2;
   localparam logic [2:0] ST_LOOK = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   localparam logic [PHASE_BITS-1:0] HALF_PHASE = PHASE_BITS'(1) << (PHASE_BITS - 1);
   localparam logic signed [SAMPLE_BITS+1:0] TRI_LO = (SAMPLE_BITS+2)'(1) << (SAMPLE_BITS - 1);
   localparam logic signed [SAMPLE_BITS+1:0] TRI_HI = (SAMPLE_BITS+2)'(3) << (SAMPLE_BITS - 1);
   localparam logic signed [SAMPLE_BITS+1:0] TRI_MAX = TRI_LO - (SAMPLE_BITS+2)'(1);
   localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [ROM_ABITS-1:0]   ROM_TOP = ROM_ABITS'(SINE_DEPTH);

   logic [2:0]              state_ff, state_in;
   logic [SR_BITS-1:0]      sample_rate_ff, sample_rate_in;
   logic [WAVE_BITS-1:0]    waveform_ff, waveform_in;
   logic [PHASE_BITS-1:0]   phase_ff, phase_in;
   logic                    neg_ff, neg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]  sample_ff, sample_in;
   logic [MAG_BITS-1:0]     rom_data_ff;

   logic                    accept;
   logic                    cfg_write;
   logic                    out_load;
   logic                    out_hold;
   logic [FREQ_BITS-1:0]    mag;
   logic [SR_BITS-1:0]      divisor;
   div_status_type          div_sts;
   logic [PHASE_BITS-1:0]   step;
   logic [IDX_BITS-1:0]     idx;
   logic [ROM_ABITS-1:0]    rom_addr;
   logic                    le_half;
   logic [SAMPLE_BITS:0]    tri_t;
   logic signed [SAMPLE_BITS+1:0] tri_s;
   logic [SAMPLE_BITS-1:0]  wave_val;

   // ---- configuration ----
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      sample_rate_in = sample_rate_ff;
      waveform_in    = waveform_ff;
      if (cfg_write) begin
         unique case (csr_paddr[2])
            REG_SAMPLE_RATE: sample_rate_in = csr_pwdata[SR_BITS-1:0];
            REG_WAVEFORM:    waveform_in    = csr_pwdata[WAVE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_SAMPLE_RATE: csr_prdata = DATA_BITS'(sample_rate_ff);
         REG_WAVEFORM:    csr_prdata = DATA_BITS'(waveform_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // ---- divide |f| * 2^24 by the sample rate (a zero rate is taken as one) ----
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign mag       = req_frequency[FREQ_BITS-1] ? FREQ_BITS'(-req_frequency)
                                                 : FREQ_BITS'(req_frequency);
   assign divisor   = (sample_rate_ff == '0) ? SR_BITS'(1) : sample_rate_ff;

   mwpo_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend ({mag, {FRAC_SHIFT{1'b0}}}),
      .divisor  (divisor),
      .status   (div_sts),
      .quotient (step)
   );

   // ---- waveform shaping from the updated phase ----
   assign idx      = phase_ff[PHASE_BITS-3 -: IDX_BITS];
   assign rom_addr = phase_ff[PHASE_BITS-2] ? ROM_TOP - ROM_ABITS'(idx) : ROM_ABITS'(idx);
   assign le_half  = (phase_ff <= HALF_PHASE);
   assign tri_t    = phase_ff[PHASE_BITS-1 -: SAMPLE_BITS+1];

   always_comb begin
      tri_s = le_half ? $signed({1'b0, tri_t}) - TRI_LO : TRI_HI - $signed({1'b0, tri_t});
      case (waveform_ff)
         WAVE_SINE: begin
            wave_val = phase_ff[PHASE_BITS-1] ? SAMPLE_BITS'(-{1'b0, rom_data_ff})
                                              : {1'b0, rom_data_ff};
         end
         WAVE_SQUARE: wave_val = le_half ? S_MIN : S_MAX;
         WAVE_SAW:    wave_val = {~phase_ff[PHASE_BITS-1],
                                  phase_ff[PHASE_BITS-2 -: SAMPLE_BITS-1]};
         default:     wave_val = (tri_s > TRI_MAX) ? S_MAX : tri_s[SAMPLE_BITS-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOOK) begin
         rom_data_ff <= SINE_ROM[rom_addr];
      end
   end

   // ---- sequencing ----
   assign out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign out_hold = (state_ff == ST_DONE) && !out_load;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      sample_in    = sample_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               neg_in   = req_frequency[FREQ_BITS-1];
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            // phase wraps naturally at 2^32; negative tones step backwards
            phase_in = neg_ff ? phase_ff - step : phase_ff + step;
            state_in = ST_LOOK;
         end
         ST_LOOK: state_in = ST_DONE;
         ST_DONE: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               sample_in    = wave_val;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         phase_ff       <= '0;
         sample_rate_ff <= SAMPLE_RATE_RESET;
         waveform_ff    <= WAVE_SINE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         sample_rate_ff <= sample_rate_in;
         waveform_ff    <= waveform_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff    <= neg_in;
      sample_ff <= sample_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = sample_ff;

`include "multi_waveform_phase_oscillator_unit_assert.svh"

   `MWPO_ASSERT_NEXT(a_accept_starts, accept, div_sts.busy, "request did not start divider")
   `MWPO_ASSERT_IMPL(a_done_in_div, div_sts.done, state_ff == ST_DIV, "divider done out of step")
   `MWPO_ASSERT_NEXT(a_hold_result, out_hold, state_ff == ST_DONE, "result dropped while stalled")

endmodule
